@@ rtl/mf3_pkg.sv @@
// shared types, constants and helpers for the 3x3 rgb mean filter
// no dependencies; used by every module of the filter by scoped names
package mf3_pkg;

    // default frame limits, handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // configuration register file
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;

    // reported position width
    localparam int POS_W = 11;

    // channel sum of nine 8-bit samples
    localparam int SUM_W = 12;

    // 2^16 / 9 rounded up, exact floor division for sums below 2296
    localparam logic [13:0] DIV9_RECIP = 14'd7282;

    // one pixel as held in the line stores and the window
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // input transfer payload
    typedef struct packed {
        logic       frame_start;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    // output transfer payload
    typedef struct packed {
        logic [7:0]       blue_mean;
        logic [7:0]       green_mean;
        logic [7:0]       red_mean;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_done;
    } t_result;

    // position info of one pixel, from the counters to the result stage
    typedef struct packed {
        logic             has_result;
        logic             frame_done;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
    } t_pos_info;

    // floor(sum / 9) by reciprocal multiply
    function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
        logic [SUM_W+13:0] prod;
        prod = {14'd0, sum} * {{SUM_W{1'b0}}, DIV9_RECIP};
        return prod[23:16];
    endfunction

endpackage

@@ rtl/mf3_position.sv @@
// row and column tracking of the incoming pixel stream
// depends on mf3_pkg for the position info struct and register widths
module mf3_position #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_frame_start,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]   i_width,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]   i_height,
    output logic [CW-1:0]                    o_col,
    output mf3_pkg::t_pos_info               o_info
);

    // compare widths, wide enough for the register, the limit and count + 1
    localparam int SW = (CW + 1 > mf3_pkg::CFG_DATA_W) ? CW + 1 : mf3_pkg::CFG_DATA_W;
    localparam int HW = (RW + 1 > mf3_pkg::CFG_DATA_W) ? RW + 1 : mf3_pkg::CFG_DATA_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic [SW-1:0] w_reg, w_eff;
    logic [HW-1:0] h_reg, h_eff;
    logic [CW-1:0] col0, col_cur;
    logic [RW-1:0] row0, row_cur;
    logic [RW:0]   row1, row_inc;
    logic [CW:0]   col_inc;
    logic [RW-1:0] row_m1;
    logic [CW-1:0] col_m1;

    // effective frame size, clamped to three and the limit
    always_comb begin
        w_reg = SW'(i_width);
        h_reg = HW'(i_height);
        if (w_reg < SW'(3)) begin
            w_eff = SW'(3);
        end else if (w_reg > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = w_reg;
        end
        if (h_reg < HW'(3)) begin
            h_eff = HW'(3);
        end else if (h_reg > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_reg;
        end
    end

    // position of the pixel now offered, and the position after it
    always_comb begin
        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;

        // counters left past the end by a size change wrap here
        if (SW'(col0) >= w_eff) begin
            col_cur = '0;
            row1    = {1'b0, row0} + (RW+1)'(1);
        end else begin
            col_cur = col0;
            row1    = {1'b0, row0};
        end
        row_cur = (HW'(row1) >= h_eff) ? '0 : row1[RW-1:0];

        col_inc = {1'b0, col_cur} + (CW+1)'(1);
        row_inc = {1'b0, row_cur} + (RW+1)'(1);
        if (SW'(col_inc) >= w_eff) begin
            n_col = '0;
            n_row = (HW'(row_inc) >= h_eff) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row_cur;
        end
    end

    // window centre sits one row up and one column left
    always_comb begin
        row_m1 = row_cur - RW'(1);
        col_m1 = col_cur - CW'(1);
        o_col  = col_cur;
        o_info.has_result = (HW'(row_cur) >= HW'(2)) && (SW'(col_cur) >= SW'(2));
        o_info.frame_done = (HW'(row_cur) == h_eff - HW'(1))
                         && (SW'(col_cur) == w_eff - SW'(1));
        o_info.center_row = mf3_pkg::POS_W'(row_m1);
        o_info.center_col = mf3_pkg::POS_W'(col_m1);
    end

    // counters advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/mf3_line_store.sv @@
// two line stores holding the previous two rows, with write-to-read bypass
// depends on mf3_pkg for the pixel type
module mf3_line_store #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [CW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [CW-1:0]     i_wr_addr,
    input  mf3_pkg::t_pixel   i_wr_upper,
    input  mf3_pkg::t_pixel   i_wr_lower,
    output mf3_pkg::t_pixel   o_upper,
    output mf3_pkg::t_pixel   o_lower
);

    mf3_pkg::t_pixel mem_upper [MAX_WIDTH];
    mf3_pkg::t_pixel mem_lower [MAX_WIDTH];

    mf3_pkg::t_pixel r_upper_q, r_lower_q;
    mf3_pkg::t_pixel r_upper_fwd, r_lower_fwd;
    logic            r_fwd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_upper[i_wr_addr] <= i_wr_upper;
            mem_lower[i_wr_addr] <= i_wr_lower;
        end
    end

    // registered read port, with the data written on the same edge kept aside
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_upper_q   <= mem_upper[i_rd_addr];
            r_lower_q   <= mem_lower[i_rd_addr];
            r_upper_fwd <= i_wr_upper;
            r_lower_fwd <= i_wr_lower;
        end
    end

    // bypass select when a read meets a write to the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_upper = r_fwd ? r_upper_fwd : r_upper_q;
    assign o_lower = r_fwd ? r_lower_fwd : r_lower_q;

endmodule

@@ rtl/mf3_window_mean.sv @@
// 3x3 window columns and per-channel mean of the nine samples
// depends on mf3_pkg for the pixel type and the divide-by-nine helper
module mf3_window_mean (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  mf3_pkg::t_pixel   i_upper,
    input  mf3_pkg::t_pixel   i_lower,
    input  mf3_pkg::t_pixel   i_pixel,
    output mf3_pkg::t_pixel   o_mean
);

    // columns one and two to the left of the current one
    mf3_pkg::t_pixel r_win [6];

    logic [mf3_pkg::SUM_W-1:0] sum_b, sum_g, sum_r;

    // sum of nine samples per channel
    always_comb begin
        sum_b = mf3_pkg::SUM_W'(i_upper.blue) + mf3_pkg::SUM_W'(i_lower.blue)
              + mf3_pkg::SUM_W'(i_pixel.blue);
        sum_g = mf3_pkg::SUM_W'(i_upper.green) + mf3_pkg::SUM_W'(i_lower.green)
              + mf3_pkg::SUM_W'(i_pixel.green);
        sum_r = mf3_pkg::SUM_W'(i_upper.red) + mf3_pkg::SUM_W'(i_lower.red)
              + mf3_pkg::SUM_W'(i_pixel.red);
        for (int j = 0; j < 6; j++) begin
            sum_b = sum_b + mf3_pkg::SUM_W'(r_win[j].blue);
            sum_g = sum_g + mf3_pkg::SUM_W'(r_win[j].green);
            sum_r = sum_r + mf3_pkg::SUM_W'(r_win[j].red);
        end
    end

    // truncated means
    always_comb begin
        o_mean.blue  = mf3_pkg::div9(sum_b);
        o_mean.green = mf3_pkg::div9(sum_g);
        o_mean.red   = mf3_pkg::div9(sum_r);
    end

    // shift the window one column on each processed pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 6; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_shift) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= i_upper;
            r_win[1] <= i_lower;
            r_win[2] <= i_pixel;
        end
    end

endmodule

@@ rtl/mean_filter_3x3_rgb.sv @@
// top level of the 3x3 rgb mean filter
// depends on mf3_pkg, mf3_position, mf3_line_store and mf3_window_mean
//
// Streaming 3x3 box filter for raster-order RGB pixels. One pixel is taken per
// clock unless a pixel with a result finds the output full; it passes an input
// stage, where the position counters advance and the two line stores are read,
// then a compute stage that forms the nine-sample means, then an output register.
// A result is given only for pixels whose window is complete (row and column of at least
// two); the result carries the centre position, one row up and one column
// left. frame_start puts a pixel at row 0, column 0; after the last pixel of a
// frame the counters wrap by themselves. Width and height are clamped to the
// range three to the MAX_WIDTH/MAX_HEIGHT limits and should be written only
// while the filter is empty. Line stores hold MAX_WIDTH pixels each and need
// no clearing after reset.
module mean_filter_3x3_rgb #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mf3_pkg::t_pix_in                  i_in_data,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mf3_pkg::t_result                  o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [mf3_pkg::CFG_DATA_W-1:0] r_width, r_height;

    logic               in_accept, s1_adv, out_free;
    logic [CW-1:0]      pos_col;
    mf3_pkg::t_pos_info pos_info;

    logic               r_s1_valid;
    mf3_pkg::t_pixel    r_s1_px;
    logic [CW-1:0]      r_s1_col;
    mf3_pkg::t_pos_info r_s1_info;

    mf3_pkg::t_pixel    ls_upper, ls_lower, mean;

    logic               r_out_valid;
    mf3_pkg::t_result   r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mf3_pkg::RST_IMAGE_WIDTH;
            r_height <= mf3_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mf3_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                mf3_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: the compute stage drains unless a result finds the output full
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!r_s1_info.has_result || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // position of the offered pixel
    mf3_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (i_in_data.frame_start),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_col         (pos_col),
        .o_info        (pos_info)
    );

    // line stores: read on transfer, written as the pixel leaves compute
    mf3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr  (pos_col),
        .i_wr_en    (s1_adv),
        .i_wr_addr  (r_s1_col),
        .i_wr_upper (ls_lower),
        .i_wr_lower (r_s1_px),
        .o_upper    (ls_upper),
        .o_lower    (ls_lower)
    );

    // compute stage item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px.blue  <= i_in_data.blue_in;
            r_s1_px.green <= i_in_data.green_in;
            r_s1_px.red   <= i_in_data.red_in;
            r_s1_col      <= pos_col;
            r_s1_info     <= pos_info;
        end
    end

    // window and means
    mf3_window_mean u_window_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_adv),
        .i_upper (ls_upper),
        .i_lower (ls_lower),
        .i_pixel (r_s1_px),
        .o_mean  (mean)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_info.has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_info.has_result) begin
            r_out_data.blue_mean  <= mean.blue;
            r_out_data.green_mean <= mean.green;
            r_out_data.red_mean   <= mean.red;
            r_out_data.center_row <= r_s1_info.center_row;
            r_out_data.center_col <= r_s1_info.center_col;
            r_out_data.frame_done <= r_s1_info.frame_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
